FILE: rtl/kced_pkg.sv
`timescale 1ns / 1ps

package kced_pkg;

  // width of the raw level input, one bit per key
  localparam int MAX_KEYS = 8;

  // per-key phase codes as kept in the state memory
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_PRESSED = 3'd1,
    PH_HOLD    = 3'd2,
    PH_LONG    = 3'd3,
    PH_SWAIT   = 3'd4,
    PH_DPRESS  = 3'd5
  } key_phase_t;

  // event codes on the result channel
  typedef enum logic [2:0] {
    EV_PRESS    = 3'd0,
    EV_RELEASE  = 3'd1,
    EV_LPRESS   = 3'd2,
    EV_LRELEASE = 3'd3,
    EV_CLICK    = 3'd4,
    EV_DCLICK   = 3'd5
  } event_code_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_DEBOUNCE     = 2'd0,
    REG_LONG_PRESS   = 2'd1,
    REG_DOUBLE_CLICK = 2'd2
  } cfg_reg_t;

  // one entry of the per-key state memory
  typedef struct packed {
    key_phase_t  phase;
    logic        stable;
    logic [3:0]  deb_cnt;
    logic [15:0] hold_cnt;
    logic [15:0] rel_cnt;
  } key_entry_t;

  localparam key_entry_t KEY_STATE_RESET = '{
    phase:    PH_IDLE,
    stable:   1'b0,
    deb_cnt:  4'd0,
    hold_cnt: 16'd0,
    rel_cnt:  16'd0
  };

  // new state of one key plus the events it raised this tick
  typedef struct packed {
    key_entry_t  state;
    logic [1:0]  ev_n;
    event_code_t ev0;
    event_code_t ev1;
  } key_update_t;

endpackage

FILE: rtl/kced_eval.sv
`timescale 1ns / 1ps

module kced_eval (
  input  kced_pkg::key_entry_t  cur,
  input  logic                  raw,
  input  logic [3:0]            debounce_ticks,
  input  logic [15:0]           long_press_ticks,
  input  logic [15:0]           double_click_ticks,
  output kced_pkg::key_update_t upd
);
  import kced_pkg::*;

  logic [3:0]  deb_inc;
  logic [15:0] hold_inc;
  logic [15:0] rel_inc;
  logic        stable_next;
  logic [3:0]  deb_next;
  logic        pressed;

  assign deb_inc  = cur.deb_cnt + 4'd1;
  assign hold_inc = cur.hold_cnt + 16'd1;
  assign rel_inc  = cur.rel_cnt + 16'd1;

  // debounce: adopt a differing level once it persisted long enough
  always_comb begin
    stable_next = cur.stable;
    deb_next    = 4'd0;
    if (raw != cur.stable) begin
      if (deb_inc >= debounce_ticks) begin
        stable_next = raw;
      end else begin
        deb_next = deb_inc;
      end
    end
  end

  assign pressed = stable_next;

  // click phase machine
  always_comb begin
    upd              = '0;
    upd.state        = cur;
    upd.state.stable = stable_next;
    upd.state.deb_cnt = deb_next;
    upd.ev_n         = 2'd0;
    upd.ev0          = EV_PRESS;
    upd.ev1          = EV_PRESS;
    unique case (cur.phase)
      PH_IDLE: begin
        if (pressed) begin
          upd.state.phase = PH_PRESSED;
        end
      end
      PH_PRESSED: begin
        upd.ev_n           = 2'd1;
        upd.ev0            = EV_PRESS;
        upd.state.hold_cnt = 16'd0;
        upd.state.phase    = PH_HOLD;
      end
      PH_HOLD: begin
        if (!pressed) begin
          upd.ev_n          = 2'd1;
          upd.ev0           = EV_RELEASE;
          upd.state.rel_cnt = 16'd0;
          upd.state.phase   = PH_SWAIT;
        end else begin
          upd.state.hold_cnt = hold_inc;
          if (hold_inc >= long_press_ticks) begin
            upd.ev_n        = 2'd1;
            upd.ev0         = EV_LPRESS;
            upd.state.phase = PH_LONG;
          end
        end
      end
      PH_LONG: begin
        if (!pressed) begin
          upd.ev_n        = 2'd1;
          upd.ev0         = EV_LRELEASE;
          upd.state.phase = PH_IDLE;
        end
      end
      PH_SWAIT: begin
        if (pressed) begin
          upd.ev_n           = 2'd1;
          upd.ev0            = EV_PRESS;
          upd.state.hold_cnt = 16'd0;
          upd.state.phase    = PH_DPRESS;
        end else begin
          upd.state.rel_cnt = rel_inc;
          if (rel_inc >= double_click_ticks) begin
            upd.ev_n        = 2'd1;
            upd.ev0         = EV_CLICK;
            upd.state.phase = PH_IDLE;
          end
        end
      end
      PH_DPRESS: begin
        if (!pressed) begin
          upd.ev_n        = 2'd2;
          upd.ev0         = EV_RELEASE;
          upd.ev1         = EV_DCLICK;
          upd.state.phase = PH_IDLE;
        end
      end
      default: begin
        upd.state.phase = PH_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/key_click_event_detector.sv
`timescale 1ns / 1ps
// per key: a state memory read, then update and write back, then emission of each
// event raised; an item enters from idle and ends with a flush of the held event
// items: a new one is taken only in idle, after the previous one has flushed;
// the result side stalling holds it up, and the memory is visited one key at a time
// reset: config back to 3 / 100 / 30, every key idle and released via entry valid bits
module key_click_event_detector #(
  parameter int KEY_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  key_levels,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  key_index,
  output logic [2:0]  event_code,
  output logic        last
);
  import kced_pkg::*;

  localparam int NKEYS = (KEY_COUNT > MAX_KEYS) ? MAX_KEYS : KEY_COUNT;
  localparam int IDX_W = (NKEYS > 1) ? $clog2(NKEYS) : 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_EVAL  = 6'b000100,
    S_EMIT0 = 6'b001000,
    S_EMIT1 = 6'b010000,
    S_FLUSH = 6'b100000
  } seq_state_t;

  seq_state_t  state;
  seq_state_t  state_next;

  logic [3:0]  debounce_ticks;
  logic [15:0] long_press_ticks;
  logic [15:0] double_click_ticks;

  key_entry_t  key_mem [NKEYS];
  key_entry_t  rdata;
  logic        rd_ok;
  logic [NKEYS-1:0] entry_valid;

  logic [NKEYS-1:0] levels;
  logic [IDX_W-1:0] key_cnt;
  logic             last_key;

  key_entry_t  cur;
  key_update_t upd;
  logic [1:0]  ev_n;
  event_code_t ev0;
  event_code_t ev1;

  // one event held back until it is known whether another follows
  logic        hold_valid;
  logic [2:0]  hold_key;
  event_code_t hold_code;

  logic        slot_free;
  logic        push;
  event_code_t push_code;
  logic        flush_out;
  logic        advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks     <= 4'd3;
      long_press_ticks   <= 16'd100;
      double_click_ticks <= 16'd30;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE:     debounce_ticks     <= cfg_data[3:0];
        REG_LONG_PRESS:   long_press_ticks   <= cfg_data;
        REG_DOUBLE_CLICK: double_click_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // state memory: read every cycle at the current key, written in the update cycle;
  // keys are visited strictly one after another so no entry is read while in flight
  always_ff @(posedge clk) begin
    rdata <= key_mem[key_cnt];
    if (state == S_EVAL) begin
      key_mem[key_cnt] <= upd.state;
    end
  end

  // entry valid bits stand in for the memory reset
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_ok       <= 1'b0;
    end else begin
      rd_ok <= entry_valid[key_cnt];
      if (state == S_EVAL) begin
        entry_valid[key_cnt] <= 1'b1;
      end
    end
  end

  assign cur = rd_ok ? rdata : KEY_STATE_RESET;

  kced_eval u_eval (
    .cur                (cur),
    .raw                (levels[key_cnt]),
    .debounce_ticks     (debounce_ticks),
    .long_press_ticks   (long_press_ticks),
    .double_click_ticks (double_click_ticks),
    .upd                (upd)
  );

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign last_key  = (key_cnt == IDX_W'(NKEYS - 1));

  // sequencer control
  always_comb begin
    state_next = state;
    push       = 1'b0;
    push_code  = ev0;
    flush_out  = 1'b0;
    advance    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (upd.ev_n == 2'd0) begin
          advance = 1'b1;
        end else begin
          state_next = S_EMIT0;
        end
      end
      S_EMIT0: begin
        if (!hold_valid || slot_free) begin
          push = 1'b1;
          if (ev_n == 2'd2) begin
            state_next = S_EMIT1;
          end else begin
            advance = 1'b1;
          end
        end
      end
      S_EMIT1: begin
        if (!hold_valid || slot_free) begin
          push      = 1'b1;
          push_code = ev1;
          advance   = 1'b1;
        end
      end
      S_FLUSH: begin
        if (!hold_valid) begin
          state_next = S_IDLE;
        end else if (slot_free) begin
          flush_out  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (advance) begin
      state_next = last_key ? S_FLUSH : S_READ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // item capture and key walk
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      levels  <= key_levels[NKEYS-1:0];
      key_cnt <= '0;
    end else if (advance && !last_key) begin
      key_cnt <= key_cnt + IDX_W'(1);
    end
  end

  // events of the key being worked on
  always_ff @(posedge clk) begin
    if (state == S_EVAL) begin
      ev_n <= upd.ev_n;
      ev0  <= upd.ev0;
      ev1  <= upd.ev1;
    end
  end

  // held event and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (push) begin
        hold_valid <= 1'b1;
      end else if (flush_out) begin
        hold_valid <= 1'b0;
      end
      if ((push && hold_valid) || flush_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      hold_key  <= 3'(key_cnt);
      hold_code <= push_code;
      if (hold_valid) begin
        key_index  <= hold_key;
        event_code <= hold_code;
        last       <= 1'b0;
      end
    end else if (flush_out) begin
      key_index  <= hold_key;
      event_code <= hold_code;
      last       <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  // a new item is only taken once the previous tick has sent its final event
  assert property (@(posedge clk) disable iff (rst) in_ready |-> !hold_valid)
    else $error("item accepted with an event still held");

  // the update cycle always follows a memory read cycle
  assert property (@(posedge clk) disable iff (rst) (state == S_EVAL) |-> $past(state) == S_READ)
    else $error("key update without a preceding state read");

  // a waiting event stays put until it is taken
  assert property (@(posedge clk) disable iff (rst)
      (out_valid && !out_ready) |=> (out_valid && $stable({key_index, event_code, last})))
    else $error("waiting event changed before it was taken");

  // event codes stay within the defined set
  assert property (@(posedge clk) disable iff (rst)
      out_valid |-> (event_code <= 3'(EV_DCLICK)))
    else $error("undefined event code on output");
`endif

endmodule
